// ----- design/qli_pkg.sv -----
// ---------------------------------------------------------------------------
// qli_pkg
// Shared constants and types for the quantile interpolation core and its
// sorter cells.
// ---------------------------------------------------------------------------
package qli_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 9;
    localparam int SAMPLE_W = 32;
    localparam int FRAC_W   = 16;
    localparam int Q_W      = 17;

    localparam logic [Q_W-1:0] Q_ONE   = Q_W'(65536);
    localparam logic [Q_W-1:0] Q_RESET = Q_W'(32768);

    // Control that every sorter cell sees in the same cycle.
    typedef struct packed {
        logic ins;    // insert the broadcast sample
        logic shift;  // move contents one place toward cell 0
        logic clr;    // drop all contents
    } t_cell_ctl;

endpackage

// ----- design/qli_cell.sv -----
// ---------------------------------------------------------------------------
// qli_cell
// One cell of the insertion sorter: holds a single sample and its valid bit,
// takes the sample from the lower neighbor when an insertion pushes the row
// up, and from the upper neighbor during readout.
// ---------------------------------------------------------------------------
module qli_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  qli_pkg::t_cell_ctl                i_ctl,
    input  logic signed [qli_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                              i_prev_gt,
    input  logic signed [qli_pkg::SAMPLE_W-1:0] i_prev_value,
    input  logic                              i_prev_valid,
    input  logic signed [qli_pkg::SAMPLE_W-1:0] i_next_value,
    input  logic                              i_next_valid,
    output logic                              o_gt,
    output logic signed [qli_pkg::SAMPLE_W-1:0] o_value,
    output logic                              o_valid
);
    import qli_pkg::*;

    logic signed [SAMPLE_W-1:0] r_value;
    logic                       r_valid;

    // An empty cell counts as larger than any sample, so equal samples
    // stay ahead of the new one.
    assign o_gt    = !r_valid || (r_value > i_sample);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clr) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
        end else if (i_ctl.ins) begin
            r_valid <= r_valid | i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value <= i_next_value;
        end else if (i_ctl.ins) begin
            if (i_prev_gt) begin
                r_value <= i_prev_value;
            end else if (o_gt) begin
                r_value <= i_sample;
            end
        end
    end

endmodule

// ----- design/quantile_linear_interp_core.sv -----
// ---------------------------------------------------------------------------
// quantile_linear_interp_core
// Sorts a set of signed Q16.16 samples in a row of insertion cells and, at
// the end of the set, returns the linearly interpolated quantile.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      tdata[31:0] sample, tlast end of set
// m_axis    out        m_axis_tvalid/tready      tdata quantile/count, tuser overflow
// cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_data quantile fraction (Q1.16)
//
// Samples are taken one per cycle while the set is being collected; every
// cell compares the broadcast sample in parallel and the row shifts up by one
// place at the insertion point. After the transfer marked tlast the core
// computes the indices (ST_CALC), reads out the row while it shifts toward
// cell 0 until both neighbors have passed (ST_SCAN), then multiplies
// (ST_MULT) and forms the interpolated result in the output register (ST_DONE).
// The input is stalled during that time and, at the end of a set, for as
// long as the previous result still sits in the output register. Reset is
// synchronous and active low; it empties the row and loads the fraction
// register with one half.
// ---------------------------------------------------------------------------
module quantile_linear_interp_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [qli_pkg::Q_W-1:0]     i_cfg_data,
    // samples
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // [31:0] sample_value
    input  logic                        s_axis_tlast,   // is_last
    // results
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [47:0]                 m_axis_tdata,   // [31:0] interp_value,
                                                        // [40:32] sample_count, rest 0
    output logic                        m_axis_tuser    // overflowed
);
    import qli_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CALC,
        ST_SCAN,
        ST_MULT,
        ST_DONE
    } t_state;

    t_state                     r_state;
    logic [Q_W-1:0]             r_q;
    logic [CNT_W-1:0]           r_count;
    logic                       r_drop;
    logic [IDX_W-1:0]           r_lo_idx;
    logic [IDX_W-1:0]           r_hi_idx;
    logic [FRAC_W-1:0]          r_frac;
    logic [IDX_W-1:0]           r_scan;
    logic signed [SAMPLE_W-1:0] r_lo;
    logic signed [SAMPLE_W-1:0] r_hi;
    logic signed [49:0]         r_prod;
    logic                       r_out_valid;
    logic [47:0]                r_out_data;
    logic                       r_out_user;

    t_cell_ctl                  w_ctl;
    logic                       w_in_xfer;
    logic                       w_full;
    logic                       w_out_free;
    logic                       w_out_load;
    logic [Q_W-1:0]             w_q_sat;
    logic [CNT_W+Q_W-1:0]       w_pos;
    logic [CNT_W-1:0]           w_last_idx;
    logic [IDX_W-1:0]           w_pos_idx;
    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [SAMPLE_W-1:0] w_result;
    logic signed [SAMPLE_W-1:0] w_sample;

    logic                       w_gt    [CAPACITY];
    logic signed [SAMPLE_W-1:0] w_value [CAPACITY];
    logic                       w_valid [CAPACITY];

    // -----------------------------------------------------------------------
    // Handshakes. The fraction register may be written at any time; the
    // user must do so only between sets, which the block does not enforce.
    // -----------------------------------------------------------------------
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_LOAD);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_W'(CAPACITY));
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_out_load    = (r_state == ST_DONE) && w_out_free;
    assign w_sample      = $signed(s_axis_tdata[SAMPLE_W-1:0]);

    assign w_ctl.ins   = w_in_xfer && !w_full;
    assign w_ctl.shift = (r_state == ST_SCAN);
    assign w_ctl.clr   = w_out_load;

    // -----------------------------------------------------------------------
    // Row of sorter cells. Cell 0 sees a virtual valid neighbor below it so
    // that an empty row fills from the bottom; the top cell reads an empty
    // neighbor during readout.
    // -----------------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                       w_pgt;
        logic signed [SAMPLE_W-1:0] w_pval;
        logic                       w_pvalid;
        logic signed [SAMPLE_W-1:0] w_nval;
        logic                       w_nvalid;

        if (g == 0) begin : g_first
            assign w_pgt    = 1'b0;
            assign w_pval   = '0;
            assign w_pvalid = 1'b1;
        end else begin : g_mid
            assign w_pgt    = w_gt[g-1];
            assign w_pval   = w_value[g-1];
            assign w_pvalid = w_valid[g-1];
        end

        if (g == CAPACITY - 1) begin : g_top
            assign w_nval   = '0;
            assign w_nvalid = 1'b0;
        end else begin : g_below
            assign w_nval   = w_value[g+1];
            assign w_nvalid = w_valid[g+1];
        end

        qli_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_sample    (w_sample),
            .i_prev_gt   (w_pgt),
            .i_prev_value(w_pval),
            .i_prev_valid(w_pvalid),
            .i_next_value(w_nval),
            .i_next_valid(w_nvalid),
            .o_gt        (w_gt[g]),
            .o_value     (w_value[g]),
            .o_valid     (w_valid[g])
        );
    end

    // -----------------------------------------------------------------------
    // Position math. The fraction saturates at one, so the integer part of
    // the position never passes the last kept index; the upper neighbor is
    // clamped to that index.
    // -----------------------------------------------------------------------
    assign w_q_sat    = (r_q > Q_ONE) ? Q_ONE : r_q;
    assign w_last_idx = r_count - CNT_W'(1);
    assign w_pos      = (CNT_W+Q_W)'(w_last_idx) * (CNT_W+Q_W)'(w_q_sat);
    assign w_pos_idx  = w_pos[FRAC_W +: IDX_W];

    // Interpolation: the arithmetic shift of the product rounds toward minus
    // infinity, and the sum wraps to 32 bits.
    assign w_diff   = $signed({r_hi[SAMPLE_W-1], r_hi})
                    - $signed({r_lo[SAMPLE_W-1], r_lo});
    assign w_result = r_lo + $signed(r_prod[FRAC_W +: SAMPLE_W]);

    // -----------------------------------------------------------------------
    // Sequencer and registered outputs.
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_q         <= Q_RESET;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_q <= i_cfg_data;
            end
            // A new result may replace the one leaving in the same cycle.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_LOAD: begin
                    if (w_in_xfer) begin
                        if (w_full) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (s_axis_tlast) begin
                            r_state <= ST_CALC;
                        end
                    end
                end
                ST_CALC: begin
                    r_lo_idx <= w_pos_idx;
                    r_hi_idx <= (CNT_W'(w_pos_idx) == w_last_idx) ? w_pos_idx
                                                                 : w_pos_idx + IDX_W'(1);
                    r_frac   <= w_pos[FRAC_W-1:0];
                    r_scan   <= '0;
                    r_state  <= ST_SCAN;
                end
                ST_SCAN: begin
                    // Cell 0 holds the sample of sorted index r_scan.
                    if (r_scan == r_lo_idx) begin
                        r_lo <= w_value[0];
                    end
                    if (r_scan == r_hi_idx) begin
                        r_hi    <= w_value[0];
                        r_state <= ST_MULT;
                    end else begin
                        r_scan <= r_scan + IDX_W'(1);
                    end
                end
                ST_MULT: begin
                    r_prod  <= w_diff * $signed({1'b0, r_frac});
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_data  <= {7'b0, r_count, w_result};
                        r_out_user  <= r_drop;
                        r_count     <= '0;
                        r_drop      <= 1'b0;
                        r_state     <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    // While collecting, the occupied cells end exactly at the kept count.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |->
            ((r_count == '0 || w_valid[IDX_W'(r_count - CNT_W'(1))]) &&
             (w_full || !w_valid[r_count[IDX_W-1:0]])))
        else $error("occupied cells differ from kept count");

    // The end of a set stops intake on the next cycle.
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input accepted right after end of set");

    // Readout never runs past the upper neighbor.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_scan <= r_hi_idx && r_lo_idx <= r_hi_idx))
        else $error("readout index out of range");

    // The kept count never exceeds the row length.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("kept count above capacity");
`endif

endmodule
